@@ hdl/rsep_pkg.sv @@
package rsep_pkg;

   // one-hot parser phases
   typedef enum logic [10:0] {
      PH_IDLE       = 11'b000_0000_0001,
      PH_INT_FIRST  = 11'b000_0000_0010,
      PH_INT_DIGITS = 11'b000_0000_0100,
      PH_INT_LF     = 11'b000_0000_1000,
      PH_BULK_LEN   = 11'b000_0001_0000,
      PH_BULK_LF    = 11'b000_0010_0000,
      PH_BULK_DATA  = 11'b000_0100_0000,
      PH_BULK_TAIL1 = 11'b000_1000_0000,
      PH_BULK_TAIL2 = 11'b001_0000_0000,
      PH_STR_BODY   = 11'b010_0000_0000,
      PH_STR_LF     = 11'b100_0000_0000
   } phase_type;

   // result kinds
   localparam logic [2:0] KIND_INT    = 3'd0;
   localparam logic [2:0] KIND_SIMPLE = 3'd1;
   localparam logic [2:0] KIND_ERROR  = 3'd2;
   localparam logic [2:0] KIND_BULK   = 3'd3;
   localparam logic [2:0] KIND_BAD    = 3'd4;

   // protocol characters
   localparam logic [7:0] CHAR_COLON  = 8'h3A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;

   // parser context that does not depend on the length width
   typedef struct packed {
      phase_type   phase;
      logic [1:0]  elem_kind;
      logic        negative;
      logic [63:0] accumulator;
   } ctx_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  payload_byte;
      logic        byte_valid;
      logic [63:0] int_value;
      logic        last;
   } result_type;

endpackage

@@ hdl/rsep_chan_if.sv @@
interface rsep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface rsep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  payload_byte;
   logic        byte_valid;
   logic [63:0] int_value;
   logic        last;

   modport source (output valid, output kind, output payload_byte, output byte_valid,
                   output int_value, output last, input ready);
   modport sink   (input valid, input kind, input payload_byte, input byte_valid,
                   input int_value, input last, output ready);
endinterface

@@ hdl/rsep_step.sv @@
module rsep_step #(
   parameter int LEN_BITS = 32
) (
   input  rsep_pkg::ctx_type     ctx,
   input  logic [LEN_BITS-1:0]   remaining,
   input  logic [LEN_BITS-1:0]   seen_length,
   input  logic [7:0]            in_byte,
   output rsep_pkg::ctx_type     ctx_next,
   output logic [LEN_BITS-1:0]   remaining_next,
   output logic [LEN_BITS-1:0]   seen_length_next,
   output logic                  emit,
   output rsep_pkg::result_type  result
);

   localparam int LW = LEN_BITS + 4;
   localparam logic [LW-1:0] LenMaxW  = LW'({LEN_BITS{1'b1}});
   localparam logic [LW-1:0] LenDiv10 = LenMaxW / 10;

   // saturating decimal step on the bulk length
   logic [LW-1:0]       len_ext, len_x10, dig_up, dig_dn, len_sum, len_dif;
   logic [LEN_BITS-1:0] len_digit_val;
   logic [63:0]         acc_digit;

   assign len_ext = LW'(seen_length);
   assign len_x10 = (len_ext << 3) + (len_ext << 1);
   assign dig_up  = LW'(in_byte) - LW'(rsep_pkg::CHAR_ZERO);
   assign dig_dn  = LW'(rsep_pkg::CHAR_ZERO) - LW'(in_byte);
   assign len_sum = len_x10 + dig_up;
   assign len_dif = len_x10 - dig_dn;

   always_comb begin
      if (len_ext > LenDiv10) begin
         len_digit_val = {LEN_BITS{1'b1}};
      end else if (in_byte >= rsep_pkg::CHAR_ZERO) begin
         len_digit_val = (len_sum > LenMaxW) ? {LEN_BITS{1'b1}} : len_sum[LEN_BITS-1:0];
      end else begin
         len_digit_val = (len_x10 < dig_dn) ? {LEN_BITS{1'b1}} : len_dif[LEN_BITS-1:0];
      end
   end

   // integer digit, wraps modulo 2^64, digits unchecked
   assign acc_digit = (ctx.accumulator << 3) + (ctx.accumulator << 1)
                      + 64'(in_byte) - 64'(rsep_pkg::CHAR_ZERO);

   always_comb begin
      ctx_next         = ctx;
      remaining_next   = remaining;
      seen_length_next = seen_length;
      emit             = 1'b0;
      result           = '0;
      unique case (ctx.phase)
         rsep_pkg::PH_IDLE: begin
            ctx_next.accumulator = '0;
            ctx_next.negative    = 1'b0;
            seen_length_next     = '0;
            remaining_next       = '0;
            if (in_byte == rsep_pkg::CHAR_COLON) begin
               ctx_next.elem_kind = rsep_pkg::KIND_INT[1:0];
               ctx_next.phase     = rsep_pkg::PH_INT_FIRST;
            end else if (in_byte == rsep_pkg::CHAR_DOLLAR) begin
               ctx_next.elem_kind = rsep_pkg::KIND_BULK[1:0];
               ctx_next.phase     = rsep_pkg::PH_BULK_LEN;
            end else if (in_byte == rsep_pkg::CHAR_PLUS) begin
               ctx_next.elem_kind = rsep_pkg::KIND_SIMPLE[1:0];
               ctx_next.phase     = rsep_pkg::PH_STR_BODY;
            end else if (in_byte == rsep_pkg::CHAR_MINUS) begin
               ctx_next.elem_kind = rsep_pkg::KIND_ERROR[1:0];
               ctx_next.phase     = rsep_pkg::PH_STR_BODY;
            end else begin
               emit        = 1'b1;
               result.kind = rsep_pkg::KIND_BAD;
               result.last = 1'b1;
            end
         end
         rsep_pkg::PH_INT_FIRST: begin
            ctx_next.phase = rsep_pkg::PH_INT_DIGITS;
            if (in_byte == rsep_pkg::CHAR_MINUS) begin
               ctx_next.negative = 1'b1;
            end else if (in_byte == rsep_pkg::CHAR_CR) begin
               ctx_next.phase = rsep_pkg::PH_INT_LF;
            end else begin
               ctx_next.accumulator = acc_digit;
            end
         end
         rsep_pkg::PH_INT_DIGITS: begin
            if (in_byte == rsep_pkg::CHAR_CR) begin
               ctx_next.phase = rsep_pkg::PH_INT_LF;
            end else begin
               ctx_next.accumulator = acc_digit;
            end
         end
         rsep_pkg::PH_INT_LF: begin
            ctx_next.phase   = rsep_pkg::PH_IDLE;
            emit             = 1'b1;
            result.kind      = rsep_pkg::KIND_INT;
            result.int_value = ctx.negative ? (64'd0 - ctx.accumulator) : ctx.accumulator;
            result.last      = 1'b1;
         end
         rsep_pkg::PH_BULK_LEN: begin
            if (in_byte == rsep_pkg::CHAR_CR) begin
               ctx_next.phase = rsep_pkg::PH_BULK_LF;
            end else begin
               seen_length_next = len_digit_val;
            end
         end
         rsep_pkg::PH_BULK_LF: begin
            remaining_next = seen_length;
            ctx_next.phase = (seen_length == '0) ? rsep_pkg::PH_BULK_TAIL1
                                                 : rsep_pkg::PH_BULK_DATA;
         end
         rsep_pkg::PH_BULK_DATA: begin
            remaining_next = remaining - 1'b1;
            if (remaining_next == '0) begin
               ctx_next.phase = rsep_pkg::PH_BULK_TAIL1;
            end
            emit                = 1'b1;
            result.kind         = rsep_pkg::KIND_BULK;
            result.payload_byte = in_byte;
            result.byte_valid   = 1'b1;
         end
         rsep_pkg::PH_BULK_TAIL1: begin
            ctx_next.phase = rsep_pkg::PH_BULK_TAIL2;
         end
         rsep_pkg::PH_BULK_TAIL2: begin
            ctx_next.phase   = rsep_pkg::PH_IDLE;
            emit             = 1'b1;
            result.kind      = rsep_pkg::KIND_BULK;
            result.int_value = 64'(seen_length);
            result.last      = 1'b1;
         end
         rsep_pkg::PH_STR_BODY: begin
            if (in_byte == rsep_pkg::CHAR_CR) begin
               ctx_next.phase = rsep_pkg::PH_STR_LF;
            end else begin
               if (seen_length != {LEN_BITS{1'b1}}) begin
                  seen_length_next = seen_length + 1'b1;
               end
               emit                = 1'b1;
               result.kind         = {1'b0, ctx.elem_kind};
               result.payload_byte = in_byte;
               result.byte_valid   = 1'b1;
            end
         end
         rsep_pkg::PH_STR_LF: begin
            ctx_next.phase   = rsep_pkg::PH_IDLE;
            emit             = 1'b1;
            result.kind      = {1'b0, ctx.elem_kind};
            result.int_value = 64'(seen_length);
            result.last      = 1'b1;
         end
         default: begin
            ctx_next.phase = rsep_pkg::PH_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/resp_element_stream_parser_core.sv @@
// A byte is accepted into the input reg; its result beat is then registered in the result reg and leaves from there.
// Throughput: 1 byte per cycle, sustained while rsp_bus.ready stays high.
// A byte that yields no result still passes the input reg and updates the parser state.
// Reset (synchronous, active high): parser context back to idle, both pipeline regs empty.
// Length counters and data regs are not reset; idle clears the counters on the next byte.
module resp_element_stream_parser_core #(
   parameter int LEN_BITS = 32
) (
   input logic         clock,
   input logic         reset,
   rsep_req_if.sink    req_bus,
   rsep_rsp_if.source  rsp_bus
);

   // ---- input register ----
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // ---- parser state ----
   rsep_pkg::ctx_type   ctx_ff, ctx_in;
   logic [LEN_BITS-1:0] remaining_ff, remaining_in;
   logic [LEN_BITS-1:0] seen_length_ff, seen_length_in;

   // ---- result register ----
   logic                 out_valid_ff, out_valid_in;
   rsep_pkg::result_type out_ff, out_in;

   // step logic outputs
   rsep_pkg::ctx_type    step_ctx;
   logic [LEN_BITS-1:0]  step_remaining, step_seen_length;
   logic                 step_emit;
   rsep_pkg::result_type step_result;

   logic advance;   // the held byte is consumed this cycle
   logic take_rsp;  // result beat handed off this cycle

   rsep_step #(
      .LEN_BITS (LEN_BITS)
   ) u_step (
      .ctx              (ctx_ff),
      .remaining        (remaining_ff),
      .seen_length      (seen_length_ff),
      .in_byte          (in_byte_ff),
      .ctx_next         (step_ctx),
      .remaining_next   (step_remaining),
      .seen_length_next (step_seen_length),
      .emit             (step_emit),
      .result           (step_result)
   );

   assign take_rsp = out_valid_ff && rsp_bus.ready;
   // the result reg can take a new beat if empty or draining this cycle
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_bus.ready);

   // input reg refills whenever it is empty or its byte moves on
   assign req_bus.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in    = in_valid_ff;
      in_byte_in     = in_byte_ff;
      ctx_in         = ctx_ff;
      remaining_in   = remaining_ff;
      seen_length_in = seen_length_ff;
      out_valid_in   = out_valid_ff;
      out_in         = out_ff;

      if (take_rsp) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         in_valid_in    = 1'b0;
         ctx_in         = step_ctx;
         remaining_in   = step_remaining;
         seen_length_in = step_seen_length;
         out_valid_in   = step_emit;
         if (step_emit) begin
            out_in = step_result;
         end
      end
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.in_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         ctx_ff       <= '{phase: rsep_pkg::PH_IDLE, elem_kind: 2'b00, negative: 1'b0,
                           accumulator: 64'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         ctx_ff       <= ctx_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff     <= in_byte_in;
      remaining_ff   <= remaining_in;
      seen_length_ff <= seen_length_in;
      out_ff         <= out_in;
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.kind         = out_ff.kind;
   assign rsp_bus.payload_byte = out_ff.payload_byte;
   assign rsp_bus.byte_valid   = out_ff.byte_valid;
   assign rsp_bus.int_value    = out_ff.int_value;
   assign rsp_bus.last         = out_ff.last;

   // ---- assertions ----

   // a payload beat never closes an element
   a_byte_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.byte_valid && rsp_bus.last))
      else $error("payload beat flagged last");

   // every element end returns the parser to idle
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && step_emit && step_result.last) |=> (ctx_ff.phase == rsep_pkg::PH_IDLE))
      else $error("element end did not return to idle");

   // a blocked byte holds in the input reg
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held input byte lost");

   // a stalled result beat is not overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> (out_valid_ff && $stable(out_ff)))
      else $error("stalled result beat changed");

   // result reg and input reg come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule
